### rtl/core/rmq_pkg.sv
// Package for the rotation matrix to quaternion block: widths, types, branch
// codes and the per-step helpers of the square root and divider pipelines.
// No dependencies.
`default_nettype none
package rmq_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DATA_W    = 16;
  localparam int NUM_W     = DATA_W + 1;
  localparam int ARG_W     = DATA_W + 2;
  localparam int ARGS_W    = DATA_W + 4;
  localparam int SQ_W      = ARG_W + FRAC_BITS;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int REM_W     = ROOT_W + 3;
  localparam int SQ_PER    = 2;
  localparam int SQ_STG    = ROOT_W / SQ_PER;
  localparam int DIV_W     = ROOT_W + 1;
  localparam int QB        = FRAC_BITS + 1;
  localparam int DVD_W     = NUM_W + FRAC_BITS + 1;
  localparam int DREM_W    = DIV_W + 1;
  localparam int DV_PER    = 3;
  localparam int DV_STG    = QB / DV_PER;
  localparam int LANES     = 3;
  localparam logic [QB-1:0] ONE = QB'(1) << FRAC_BITS;

  localparam logic [1:0] SEL_X = 2'd0;
  localparam logic [1:0] SEL_Y = 2'd1;
  localparam logic [1:0] SEL_Z = 2'd2;
  localparam logic [1:0] SEL_W = 2'd3;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [NUM_W-1:0] num_t;

  typedef struct packed {
    data_t m00; data_t m01; data_t m02;
    data_t m10; data_t m11; data_t m12;
    data_t m20; data_t m21; data_t m22;
  } mat_t;

  typedef struct packed {
    data_t qx; data_t qy; data_t qz; data_t qw;
  } quat_t;

  typedef struct packed {
    logic             valid;
    logic [1:0]       sel;
    num_t [LANES-1:0] nums;
  } tag_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   rad;
  } sq_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [QB-1:0]     low;
    logic [QB-1:0]     q;
    logic              sat;
    logic              neg;
  } dv_t;

  function automatic sq_t sq_step(sq_t s);
    sq_t              r;
    logic [REM_W-1:0] t;
    logic [REM_W-1:0] sh;
    r  = s;
    sh = {s.rem[REM_W-3:0], s.rad[SQ_W-1 -: 2]};
    t  = {1'b0, s.root, 2'b01};
    r.rad = {s.rad[SQ_W-3:0], 2'b00};
    if (sh >= t) begin
      r.rem  = sh - t;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = sh;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic dv_t dv_step(dv_t s, logic [DIV_W-1:0] d);
    dv_t               r;
    logic [DREM_W-1:0] sh;
    r  = s;
    sh = {s.rem[DREM_W-2:0], s.low[QB-1]};
    r.low = {s.low[QB-2:0], 1'b0};
    if (sh >= {1'b0, d}) begin
      r.rem = sh - {1'b0, d};
      r.q   = {s.q[QB-2:0], 1'b1};
    end else begin
      r.rem = sh;
      r.q   = {s.q[QB-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/core/rmq_if.sv
// Valid/ready channel interfaces for matrices in and quaternions out.
// Depends on rmq_pkg.
`default_nettype none
interface rmq_mat_if (input logic clk_i);
  import rmq_pkg::*;
  logic valid;
  logic ready;
  mat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rmq_quat_if (input logic clk_i);
  import rmq_pkg::*;
  logic  valid;
  logic  ready;
  quat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/rmq_front.sv
// First stage: trace, branch select, square root argument and numerators.
// Depends on rmq_pkg.
`default_nettype none
module rmq_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  rmq_pkg::mat_t          mat_i,
  output rmq_pkg::tag_t          tag_o,
  output logic [rmq_pkg::ARG_W-1:0] arg_o
);
  import rmq_pkg::*;

  logic signed [ARGS_W-1:0] e00, e11, e22, trace, arg_s;
  logic signed [NUM_W-1:0]  na, nb, nc, sxy, sxz, syz;
  tag_t                     tag_d;
  logic                     valid_q;
  logic [1:0]               sel_q;
  num_t [LANES-1:0]         nums_q;
  logic [ARG_W-1:0]         arg_d, arg_q;

  always_comb begin
    e00   = ARGS_W'(mat_i.m00);
    e11   = ARGS_W'(mat_i.m11);
    e22   = ARGS_W'(mat_i.m22);
    trace = e00 + e11 + e22;
    na    = NUM_W'(mat_i.m21) - NUM_W'(mat_i.m12);
    nb    = NUM_W'(mat_i.m02) - NUM_W'(mat_i.m20);
    nc    = NUM_W'(mat_i.m10) - NUM_W'(mat_i.m01);
    sxy   = NUM_W'(mat_i.m01) + NUM_W'(mat_i.m10);
    sxz   = NUM_W'(mat_i.m02) + NUM_W'(mat_i.m20);
    syz   = NUM_W'(mat_i.m12) + NUM_W'(mat_i.m21);
    tag_d.valid = valid_i;
    if (trace > 0) begin
      tag_d.sel  = SEL_W;
      arg_s      = trace + ARGS_W'(ONE);
      tag_d.nums = {nc, nb, na};
    end else if (e00 > e11 && e00 > e22) begin
      tag_d.sel  = SEL_X;
      arg_s      = ARGS_W'(ONE) + e00 - e11 - e22;
      tag_d.nums = {na, sxz, sxy};
    end else if (e11 > e22) begin
      tag_d.sel  = SEL_Y;
      arg_s      = ARGS_W'(ONE) + e11 - e00 - e22;
      tag_d.nums = {nb, syz, sxy};
    end else begin
      tag_d.sel  = SEL_Z;
      arg_s      = ARGS_W'(ONE) + e22 - e00 - e11;
      tag_d.nums = {nc, syz, sxz};
    end
    arg_d = (arg_s < 0) ? '0 : arg_s[ARG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= tag_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sel_q  <= tag_d.sel;
      nums_q <= tag_d.nums;
      arg_q  <= arg_d;
    end
  end

  assign tag_o = {valid_q, sel_q, nums_q};
  assign arg_o = arg_q;
endmodule
`default_nettype wire

### rtl/core/rmq_sqrt.sv
// Pipelined digit-by-digit square root, two result bits per stage.
// Depends on rmq_pkg.
`default_nettype none
module rmq_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  rmq_pkg::tag_t              tag_i,
  input  logic [rmq_pkg::ARG_W-1:0]  arg_i,
  output rmq_pkg::tag_t              tag_o,
  output logic [rmq_pkg::ROOT_W-1:0] root_o
);
  import rmq_pkg::*;

  logic             v_q    [SQ_STG];
  logic [1:0]       sel_q  [SQ_STG];
  num_t [LANES-1:0] nums_q [SQ_STG];
  sq_t              sq_q   [SQ_STG];
  sq_t              sq_d   [SQ_STG];
  tag_t             tag_d  [SQ_STG];

  always_comb begin
    for (int s = 0; s < SQ_STG; s++) begin
      sq_t cur;
      if (s == 0) begin
        cur.rem  = '0;
        cur.root = '0;
        cur.rad  = {arg_i, {FRAC_BITS{1'b0}}};
        tag_d[s] = tag_i;
      end else begin
        cur      = sq_q[s-1];
        tag_d[s] = {v_q[s-1], sel_q[s-1], nums_q[s-1]};
      end
      for (int k = 0; k < SQ_PER; k++) begin
        cur = sq_step(cur);
      end
      sq_d[s] = cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SQ_STG; s++) v_q[s] <= 1'b0;
    end else if (en_i) begin
      for (int s = 0; s < SQ_STG; s++) v_q[s] <= tag_d[s].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < SQ_STG; s++) begin
        sel_q[s]  <= tag_d[s].sel;
        nums_q[s] <= tag_d[s].nums;
        sq_q[s]   <= sq_d[s];
      end
    end
  end

  assign tag_o  = {v_q[SQ_STG-1], sel_q[SQ_STG-1], nums_q[SQ_STG-1]};
  assign root_o = sq_q[SQ_STG-1].root;
endmodule
`default_nettype wire

### rtl/core/rmq_div.sv
// Rounded division of three numerators by twice the root, pipelined three
// quotient bits per stage, then saturation and mapping to x, y, z, w.
// Depends on rmq_pkg.
`default_nettype none
module rmq_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  rmq_pkg::tag_t              tag_i,
  input  logic [rmq_pkg::ROOT_W-1:0] root_i,
  output logic                       valid_o,
  output rmq_pkg::quat_t             quat_o
);
  import rmq_pkg::*;

  localparam int NST = DV_STG + 1;

  logic                    v_q    [NST];
  logic                    v_d    [NST];
  logic [1:0]              sel_q  [NST];
  logic [1:0]              sel_d  [NST];
  logic [ROOT_W-1:0]       root_q [NST];
  logic [ROOT_W-1:0]       root_d [NST];
  dv_t  [LANES-1:0]        dv_q   [NST];
  dv_t  [LANES-1:0]        dv_d   [NST];
  logic                    out_v_q;
  quat_t                   quat_d, quat_q;

  function automatic data_t lane_val(dv_t l, logic [ROOT_W-1:0] root);
    logic [QB-1:0] mag;
    if (root == '0) mag = '0;
    else if (l.sat || l.q > ONE) mag = ONE;
    else mag = l.q;
    return l.neg ? -DATA_W'(mag) : DATA_W'(mag);
  endfunction

  always_comb begin
    for (int s = 0; s < NST; s++) begin
      if (s == 0) begin
        v_d[s]    = tag_i.valid;
        sel_d[s]  = tag_i.sel;
        root_d[s] = root_i;
        for (int i = 0; i < LANES; i++) begin
          logic signed [NUM_W-1:0] n;
          logic [NUM_W-1:0]        mag;
          logic [DVD_W-1:0]        dvd;
          logic [DIV_W-1:0]        dd;
          n   = $signed(tag_i.nums[i]);
          mag = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
          dd  = {root_i, 1'b0};
          dvd = {1'b0, mag, {FRAC_BITS{1'b0}}} + DVD_W'(root_i);
          dv_d[s][i].neg = n[NUM_W-1];
          dv_d[s][i].sat = dvd[DVD_W-1:QB] >= dd;
          dv_d[s][i].rem = {1'b0, dvd[DVD_W-1:QB]};
          dv_d[s][i].low = dvd[QB-1:0];
          dv_d[s][i].q   = '0;
        end
      end else begin
        v_d[s]    = v_q[s-1];
        sel_d[s]  = sel_q[s-1];
        root_d[s] = root_q[s-1];
        for (int i = 0; i < LANES; i++) begin
          dv_t cur;
          cur = dv_q[s-1][i];
          for (int k = 0; k < DV_PER; k++) begin
            cur = dv_step(cur, {root_q[s-1], 1'b0});
          end
          dv_d[s][i] = cur;
        end
      end
    end
  end

  always_comb begin
    logic [1:0]        sel;
    logic [ROOT_W-1:0] root;
    logic [ROOT_W:0]   hsum;
    data_t             half;
    data_t             val [4];
    sel  = sel_q[NST-1];
    root = root_q[NST-1];
    hsum = {1'b0, root} + 1'b1;
    half = (hsum[ROOT_W:1] > ROOT_W'(ONE)) ? DATA_W'(ONE) : DATA_W'(hsum[ROOT_W:1]);
    for (int p = 0; p < 4; p++) begin
      if (p == int'(sel)) val[p] = half;
      else if (p < int'(sel)) val[p] = lane_val(dv_q[NST-1][p], root);
      else val[p] = lane_val(dv_q[NST-1][p-1], root);
    end
    quat_d.qx = val[0];
    quat_d.qy = val[1];
    quat_d.qz = val[2];
    quat_d.qw = val[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NST; s++) v_q[s] <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en_i) begin
      for (int s = 0; s < NST; s++) v_q[s] <= v_d[s];
      out_v_q <= v_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NST; s++) begin
        sel_q[s]  <= sel_d[s];
        root_q[s] <= root_d[s];
        dv_q[s]   <= dv_d[s];
      end
      quat_q <= quat_d;
    end
  end

  assign valid_o = out_v_q;
  assign quat_o  = quat_q;
endmodule
`default_nettype wire

### rtl/core/rotation_matrix_to_quaternion_top.sv
// Rotation matrix to unit quaternion converter.
// Channels: mat_i (sink) takes nine Q1.14 matrix entries per transaction;
// quat_o (source) returns qx, qy, qz, qw in Q1.14, saturated to +/-1.0.
// One transaction is accepted whenever valid and ready are both high.
// Path to quat_o.valid: an accepted matrix passes through 16 register stages
// (1 front, 8 square root, 1 divider setup, 5 divider, 1 output register).
// Throughput: one matrix per cycle while quat_o is not stalled; every stage
// is a register with a valid bit that moves with its data.
// Stall: while quat_o holds a transaction that is not taken, the whole pipe
// holds and mat_i.ready is low; bubbles advance freely otherwise.
// Reset (rst_ni low, asynchronous) clears all valid bits; data registers are
// not reset. No configuration and no state between transactions.
// Depends on rmq_pkg, rmq_if, rmq_front, rmq_sqrt, rmq_div.
`default_nettype none
module rotation_matrix_to_quaternion_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  rmq_mat_if.sink         mat_i,
  rmq_quat_if.source      quat_o
);
  import rmq_pkg::*;

  logic              en;
  tag_t              front_tag, sq_tag;
  logic [ARG_W-1:0]  arg;
  logic [ROOT_W-1:0] root;

  assign en          = !quat_o.valid || quat_o.ready;
  assign mat_i.ready = en;

  rmq_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mat_i.valid),
    .mat_i   (mat_i.data),
    .tag_o   (front_tag),
    .arg_o   (arg)
  );

  rmq_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .tag_i  (front_tag),
    .arg_i  (arg),
    .tag_o  (sq_tag),
    .root_o (root)
  );

  rmq_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .tag_i   (sq_tag),
    .root_i  (root),
    .valid_o (quat_o.valid),
    .quat_o  (quat_o.data)
  );
endmodule
`default_nettype wire

### rtl/core/rmq_checker.sv
// Port-level checks for the quaternion converter, bound to the top level.
// Depends on rmq_pkg.
`default_nettype none
module rmq_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input rmq_pkg::quat_t out_data_i
);
  import rmq_pkg::*;

  localparam data_t POS1 = DATA_W'(ONE);
  localparam data_t NEG1 = -DATA_W'(ONE);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped or changed under stall");

  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready does not follow output side");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_data_i.qx <= POS1 && out_data_i.qx >= NEG1 &&
                    out_data_i.qy <= POS1 && out_data_i.qy >= NEG1 &&
                    out_data_i.qz <= POS1 && out_data_i.qz >= NEG1 &&
                    out_data_i.qw <= POS1 && out_data_i.qw >= NEG1)
    else $error("component outside +/-1.0");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid right after reset");

  a_stall_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !(in_valid_i && in_ready_i))
    else $error("transaction accepted while pipe is held");
endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_rmq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (mat_i.valid),
  .in_ready_i  (mat_i.ready),
  .out_valid_i (quat_o.valid),
  .out_ready_i (quat_o.ready),
  .out_data_i  (quat_o.data)
);
`default_nettype wire
